@@ sv/tpfg_pkg.sv @@
`default_nettype none
package tpfg_pkg;

  localparam int unsigned TIME_WIDTH_DEF     = 32;
  localparam int unsigned SINE_ADDR_BITS_DEF = 10;
  localparam int unsigned SAMPLE_WIDTH_DEF   = 32;

  localparam int unsigned ENV_FRAC = 30;
  localparam int unsigned QUO_W    = ENV_FRAC + 1;
  localparam int unsigned SLOPE_W  = 31;
  localparam int unsigned K_W      = 46;

  localparam logic [K_W-1:0]     SLOPE_K    = 46'd44798133900175;
  localparam logic [SLOPE_W-1:0] SLOPE_MAX  = 31'h7fff_ffff;
  localparam logic [63:0]        ONE_Q30    = 64'd1 << ENV_FRAC;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  // Taylor denominators (2j)(2j+1), j = 1..8
  localparam logic [63:0] QS_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                         64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [2:0] {
    CFG_MAJOR_AMP     = 3'd0,
    CFG_MINOR_AMP     = 3'd1,
    CFG_PHASE_STEP    = 3'd2,
    CFG_PHASE_OFFSET  = 3'd3,
    CFG_START_DELAY   = 3'd4,
    CFG_RAMP_UP_LEN   = 3'd5,
    CFG_PLATEAU_LEN   = 3'd6,
    CFG_RAMP_DOWN_LEN = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEG_ZERO = 2'd0,
    SEG_RISE = 2'd1,
    SEG_FLAT = 2'd2,
    SEG_FALL = 2'd3
  } seg_e;

  typedef struct packed {
    logic [15:0]        major_amp;
    logic [15:0]        minor_amp;
    logic [31:0]        phase_step;
    logic [31:0]        phase_offset;
    logic [31:0]        start_delay;
    logic [31:0]        ramp_up_len;
    logic [31:0]        plateau_len;
    logic [31:0]        ramp_down_len;
    logic [SLOPE_W-1:0] slope_up;
    logic [SLOPE_W-1:0] slope_dn;
  } cfg_regs_t;

  function automatic logic [63:0] quarter_sine(int unsigned sab, logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    x  = (k * HALF_PI_Q30) >> (sab - 2);
    x2 = (x * x) >> ENV_FRAC;
    r  = ONE_Q30;
    for (int j = 7; j >= 0; j--) begin
      r = ONE_Q30 - (((x2 * r) >> ENV_FRAC) / QS_DIV[j]);
    end
    return (x * r) >> ENV_FRAC;
  endfunction

  function automatic logic signed [31:0] sine_entry(int unsigned sab, int unsigned a);
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] k;
    logic [63:0] v;
    n = 64'd1 << (sab - 2);
    q = 64'(a) >> (sab - 2);
    k = 64'(a) & (n - 64'd1);
    v = q[0] ? quarter_sine(sab, n - k) : quarter_sine(sab, k);
    return q[1] ? -$signed(v[31:0]) : $signed(v[31:0]);
  endfunction

endpackage
`default_nettype wire

@@ sv/tpfg_cfg.sv @@
`default_nettype none
module tpfg_cfg #(
  parameter int unsigned TIME_WIDTH = tpfg_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [31:0]           cfg_data_i,
  output tpfg_pkg::cfg_regs_t        regs_o,
  output logic [TIME_WIDTH+1:0]      t2_o,
  output logic [TIME_WIDTH+1:0]      t3_o,
  output logic                       busy_o
);

  localparam int unsigned DW   = TIME_WIDTH + 32;
  localparam int unsigned KW   = tpfg_pkg::K_W;
  localparam int unsigned CMAX = (TIME_WIDTH > KW) ? TIME_WIDTH : KW;
  localparam int unsigned CW   = $clog2(CMAX);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  tpfg_pkg::cfg_regs_t regs_q;
  logic [1:0]            state_q;
  logic                  side_q;
  logic [CW-1:0]         cnt_q;
  logic [DW-1:0]         acc_q;
  logic [DW-1:0]         ps_sh_q;
  logic [TIME_WIDTH-1:0] len_sh_q;
  logic [DW-1:0]         rem_q;
  logic [KW-1:0]         k_sh_q;
  logic [KW-1:0]         quo_q;
  logic [TIME_WIDTH+1:0] t2_q;
  logic [TIME_WIDTH+1:0] t3_q;

  logic [DW-1:0]          rr;
  logic                   ge;
  logic [KW-1:0]          quo_d;
  logic [tpfg_pkg::SLOPE_W-1:0] slope_d;

  always_comb begin
    rr      = {rem_q[DW-2:0], k_sh_q[KW-1]};
    ge      = (rr >= acc_q);
    quo_d   = {quo_q[KW-2:0], ge};
    slope_d = (quo_d[KW-1:tpfg_pkg::SLOPE_W] != '0) ? tpfg_pkg::SLOPE_MAX
                                                    : quo_d[tpfg_pkg::SLOPE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q  <= '{slope_up: tpfg_pkg::SLOPE_MAX, slope_dn: tpfg_pkg::SLOPE_MAX,
                   default: '0};
      state_q <= S_IDLE;
      side_q  <= 1'b0;
      cnt_q   <= '0;
      t2_q    <= '0;
      t3_q    <= '0;
    end else begin
      t2_q <= {2'b00, TIME_WIDTH'(regs_q.ramp_up_len)}
              + {2'b00, TIME_WIDTH'(regs_q.plateau_len)};
      t3_q <= t2_q + {2'b00, TIME_WIDTH'(regs_q.ramp_down_len)};
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              tpfg_pkg::CFG_MAJOR_AMP:     regs_q.major_amp     <= cfg_data_i[15:0];
              tpfg_pkg::CFG_MINOR_AMP:     regs_q.minor_amp     <= cfg_data_i[15:0];
              tpfg_pkg::CFG_PHASE_STEP:    regs_q.phase_step    <= cfg_data_i;
              tpfg_pkg::CFG_PHASE_OFFSET:  regs_q.phase_offset  <= cfg_data_i;
              tpfg_pkg::CFG_START_DELAY:   regs_q.start_delay   <= cfg_data_i;
              tpfg_pkg::CFG_RAMP_UP_LEN:   regs_q.ramp_up_len   <= cfg_data_i;
              tpfg_pkg::CFG_PLATEAU_LEN:   regs_q.plateau_len   <= cfg_data_i;
              tpfg_pkg::CFG_RAMP_DOWN_LEN: regs_q.ramp_down_len <= cfg_data_i;
              default: ;
            endcase
            side_q  <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_q <= S_MUL;
          cnt_q   <= '0;
        end
        S_MUL: begin
          if (cnt_q == CW'(TIME_WIDTH - 1)) begin
            state_q <= S_DIV;
            cnt_q   <= CW'(KW - 1);
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            if (side_q) begin
              regs_q.slope_dn <= slope_d;
              state_q         <= S_IDLE;
            end else begin
              regs_q.slope_up <= slope_d;
              side_q          <= 1'b1;
              state_q         <= S_LOAD;
            end
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // shift-add multiply for phase_step * len, then restoring divide of K
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LOAD: begin
        acc_q    <= '0;
        ps_sh_q  <= DW'(regs_q.phase_step);
        len_sh_q <= side_q ? TIME_WIDTH'(regs_q.ramp_down_len)
                           : TIME_WIDTH'(regs_q.ramp_up_len);
        rem_q    <= '0;
        k_sh_q   <= tpfg_pkg::SLOPE_K;
        quo_q    <= '0;
      end
      S_MUL: begin
        if (len_sh_q[0]) acc_q <= acc_q + ps_sh_q;
        ps_sh_q  <= {ps_sh_q[DW-2:0], 1'b0};
        len_sh_q <= len_sh_q >> 1;
      end
      S_DIV: begin
        rem_q  <= ge ? (rr - acc_q) : rr;
        k_sh_q <= {k_sh_q[KW-2:0], 1'b0};
        quo_q  <= quo_d;
      end
      default: ;
    endcase
  end

  assign regs_o      = regs_q;
  assign t2_o        = t2_q;
  assign t3_o        = t3_q;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

@@ sv/tpfg_front.sv @@
`default_nettype none
module tpfg_front #(
  parameter int unsigned TIME_WIDTH = tpfg_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  command_i,
  input  wire logic [31:0]           time_tick_i,
  input  wire tpfg_pkg::cfg_regs_t   regs_i,
  input  wire logic [TIME_WIDTH+1:0] t2_i,
  input  wire logic [TIME_WIDTH+1:0] t3_i,
  input  wire logic                  busy_i,
  input  wire logic                  push_ok_i,
  output logic                       push_o,
  output logic                       cmd_o,
  output tpfg_pkg::seg_e             seg_o,
  output logic                       inside_o,
  output logic [TIME_WIDTH-1:0]      num_o,
  output logic [31:0]                phase_o
);

  logic                  fen;
  logic                  fa_valid_q;
  logic                  fa_cmd_q;
  logic                  fa_before_q;
  logic [TIME_WIDTH-1:0] fa_t_q;
  logic                  fb_valid_q;
  logic                  fb_cmd_q;
  tpfg_pkg::seg_e        fb_seg_q;
  logic                  fb_inside_q;
  logic [TIME_WIDTH-1:0] fb_num_q;
  logic [31:0]           fb_phase_q;

  logic [TIME_WIDTH-1:0] tt;
  logic [TIME_WIDTH-1:0] dly;
  logic [TIME_WIDTH+1:0] t_ext;
  logic [TIME_WIDTH+1:0] t1_ext;
  tpfg_pkg::seg_e        seg_d;
  logic [TIME_WIDTH-1:0] num_d;
  logic                  inside_d;

  assign fen        = !fb_valid_q || push_ok_i;
  assign in_stall_o = busy_i || !fen;
  assign tt         = TIME_WIDTH'(time_tick_i);
  assign dly        = TIME_WIDTH'(regs_i.start_delay);

  always_comb begin
    t_ext  = {2'b00, fa_t_q};
    t1_ext = {2'b00, TIME_WIDTH'(regs_i.ramp_up_len)};
    if (fa_before_q || fa_t_q == '0) begin
      seg_d = tpfg_pkg::SEG_ZERO;
    end else if (t_ext <= t1_ext) begin
      seg_d = tpfg_pkg::SEG_RISE;
    end else if (t_ext <= t2_i) begin
      seg_d = tpfg_pkg::SEG_FLAT;
    end else if (t_ext <= t3_i) begin
      seg_d = tpfg_pkg::SEG_FALL;
    end else begin
      seg_d = tpfg_pkg::SEG_ZERO;
    end
    inside_d = !fa_before_q && (fa_t_q != '0) && (t_ext < t3_i);
    case (seg_d)
      tpfg_pkg::SEG_RISE: num_d = fa_t_q;
      tpfg_pkg::SEG_FALL: num_d = TIME_WIDTH'(t3_i - t_ext);
      default:            num_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_valid_q <= 1'b0;
      fb_valid_q <= 1'b0;
    end else if (fen) begin
      fa_valid_q <= in_valid_i && !busy_i;
      fb_valid_q <= fa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      fa_cmd_q    <= command_i;
      fa_before_q <= (tt < dly);
      fa_t_q      <= tt - dly;
      fb_cmd_q    <= fa_cmd_q;
      fb_seg_q    <= seg_d;
      fb_inside_q <= inside_d;
      fb_num_q    <= num_d;
      fb_phase_q  <= 32'(regs_i.phase_step * 32'(fa_t_q));
    end
  end

  assign push_o   = fb_valid_q && push_ok_i;
  assign cmd_o    = fb_cmd_q;
  assign seg_o    = fb_seg_q;
  assign inside_o = fb_inside_q;
  assign num_o    = fb_num_q;
  assign phase_o  = fb_phase_q;

endmodule
`default_nettype wire

@@ sv/tpfg_fifo.sv @@
`default_nettype none
module tpfg_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  push_ok_o,
  input  wire logic             pop_i,
  output logic                  nonempty_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;

  assign nonempty_o = (cnt_q != 2'd0);
  assign push_ok_o  = (cnt_q != 2'd2) || pop_i;
  assign data_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

@@ sv/tpfg_div.sv @@
`default_nettype none
module tpfg_div #(
  parameter int unsigned TIME_WIDTH = tpfg_pkg::TIME_WIDTH_DEF,
  parameter int unsigned TAG_W      = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [TIME_WIDTH-1:0] num_i,
  input  wire logic                  sel_i,
  input  wire logic [TIME_WIDTH-1:0] den_a_i,
  input  wire logic [TIME_WIDTH-1:0] den_b_i,
  input  wire logic [TAG_W-1:0]      tag_i,
  output logic                       valid_o,
  output logic [tpfg_pkg::QUO_W-1:0] quo_o,
  output logic [TAG_W-1:0]           tag_o
);

  localparam int unsigned NS = tpfg_pkg::QUO_W;

  logic                        vld_q [NS];
  logic                        sel_q [NS];
  logic [TIME_WIDTH-1:0]       rem_q [NS];
  logic [NS-1:0]               quo_q [NS];
  logic [TAG_W-1:0]            tag_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [TIME_WIDTH:0]   rr;
    logic [TIME_WIDTH-1:0] den;
    logic                  ge;
    logic                  vld_in;
    logic                  sel_in;
    logic [NS-1:0]         quo_in;
    logic [TAG_W-1:0]      tag_in;

    if (s == 0) begin : g_first
      assign rr     = {1'b0, num_i};
      assign vld_in = valid_i;
      assign sel_in = sel_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rr     = {rem_q[s-1], 1'b0};
      assign vld_in = vld_q[s-1];
      assign sel_in = sel_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign den = sel_in ? den_b_i : den_a_i;
    assign ge  = (rr >= {1'b0, den});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sel_q[s] <= sel_in;
        rem_q[s] <= ge ? TIME_WIDTH'(rr - {1'b0, den}) : TIME_WIDTH'(rr);
        quo_q[s] <= {quo_in[NS-2:0], ge};
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign tag_o   = tag_q[NS-1];

endmodule
`default_nettype wire

@@ sv/tpfg_back.sv @@
`default_nettype none
module tpfg_back #(
  parameter int unsigned TIME_WIDTH     = tpfg_pkg::TIME_WIDTH_DEF,
  parameter int unsigned SINE_ADDR_BITS = tpfg_pkg::SINE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_WIDTH   = tpfg_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tpfg_pkg::cfg_regs_t   regs_i,
  input  wire logic                  nonempty_i,
  output logic                       pop_o,
  input  wire logic                  cmd_i,
  input  wire tpfg_pkg::seg_e        seg_i,
  input  wire logic                  inside_i,
  input  wire logic [TIME_WIDTH-1:0] num_i,
  input  wire logic [31:0]           phase_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [31:0]         major_component_o,
  output logic signed [31:0]         minor_component_o,
  output logic                       in_pulse_o
);

  localparam int unsigned SAB   = SINE_ADDR_BITS;
  localparam int unsigned NROM  = 2 ** SAB;
  localparam int unsigned TAG_W = 4 + SAB;
  localparam int unsigned QW    = tpfg_pkg::QUO_W;
  localparam int unsigned SWE   = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
  localparam logic [SAB-1:0]   QTR    = SAB'(1) << (SAB - 2);
  localparam logic signed [49:0] SAT_HI = (50'sd1 <<< (SWE - 1)) - 50'sd1;
  localparam logic signed [49:0] SAT_LO = -SAT_HI - 50'sd1;

  logic en;

  logic signed [31:0] rom [NROM];
  for (genvar g = 0; g < NROM; g++) begin : g_rom
    assign rom[g] = tpfg_pkg::sine_entry(SAB, g);
  end

  // entry stage
  logic                  b0_valid_q;
  logic                  b0_cmd_q;
  tpfg_pkg::seg_e        b0_seg_q;
  logic                  b0_inside_q;
  logic [TIME_WIDTH-1:0] b0_num_q;
  logic [SAB-1:0]        b0_addr_q;
  logic [31:0]           phase_sum;

  assign en        = !out_valid_o || !out_stall_i;
  assign pop_o     = en && nonempty_i;
  assign phase_sum = phase_i + regs_i.phase_offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q <= 1'b0;
    end else if (en) begin
      b0_valid_q <= nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_cmd_q    <= cmd_i;
      b0_seg_q    <= seg_i;
      b0_inside_q <= inside_i;
      b0_num_q    <= num_i;
      b0_addr_q   <= phase_sum[31 -: SAB];
    end
  end

  // envelope divide
  logic             dv_valid;
  logic [QW-1:0]    dv_quo;
  logic [TAG_W-1:0] dv_tag;

  tpfg_div #(
    .TIME_WIDTH (TIME_WIDTH),
    .TAG_W      (TAG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b0_valid_q),
    .num_i   (b0_num_q),
    .sel_i   (b0_seg_q == tpfg_pkg::SEG_FALL),
    .den_a_i (TIME_WIDTH'(regs_i.ramp_up_len)),
    .den_b_i (TIME_WIDTH'(regs_i.ramp_down_len)),
    .tag_i   ({b0_cmd_q, b0_seg_q, b0_inside_q, b0_addr_q}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  logic           t_cmd;
  tpfg_pkg::seg_e t_seg;
  logic           t_inside;
  logic [SAB-1:0] t_addr;
  assign {t_cmd, t_seg, t_inside, t_addr} = dv_tag;

  // E1: envelope, slope, table read
  logic               e1_valid_q, e1_cmd_q, e1_inside_q;
  logic [QW-1:0]      e1_env_q;
  logic signed [31:0] e1_dq_q, e1_sn_q, e1_cs_q;
  logic [QW-1:0]      env_d;
  logic signed [31:0] dq_d;

  always_comb begin
    case (t_seg)
      tpfg_pkg::SEG_RISE: begin
        env_d = dv_quo;
        dq_d  = $signed({1'b0, regs_i.slope_up});
      end
      tpfg_pkg::SEG_FALL: begin
        env_d = dv_quo;
        dq_d  = -$signed({1'b0, regs_i.slope_dn});
      end
      tpfg_pkg::SEG_FLAT: begin
        env_d = QW'(tpfg_pkg::ONE_Q30);
        dq_d  = '0;
      end
      default: begin
        env_d = '0;
        dq_d  = '0;
      end
    endcase
  end

  // E2: products
  logic               e2_valid_q, e2_cmd_q, e2_inside_q;
  logic signed [63:0] e2_pes_q, e2_pec_q, e2_pds_q, e2_pdc_q;
  // E3: scaled terms
  logic               e3_valid_q, e3_cmd_q, e3_inside_q;
  logic signed [33:0] e3_es_q, e3_ec_q;
  logic signed [47:0] e3_ds_q, e3_dc_q;
  // E4: components before amplitude
  logic               e4_valid_q, e4_inside_q;
  logic signed [48:0] e4_maj_q, e4_mnr_q;
  // E5: amplitude products
  logic               e5_valid_q, e5_inside_q;
  logic signed [65:0] e5_pmaj_q, e5_pmnr_q;
  // output word
  logic               out_valid_q, out_inside_q;
  logic signed [31:0] out_maj_q, out_mnr_q;

  logic signed [63:0] pes_a, pec_a, pds_a, pdc_a;
  logic signed [65:0] pmaj_a, pmnr_a;
  logic signed [49:0] vmaj, vmnr;
  logic signed [31:0] smaj, smnr;

  always_comb begin
    pes_a  = e2_pes_q + $signed({34'b0, {30{e2_pes_q[63]}}});
    pec_a  = e2_pec_q + $signed({34'b0, {30{e2_pec_q[63]}}});
    pds_a  = e2_pds_q + $signed({48'b0, {16{e2_pds_q[63]}}});
    pdc_a  = e2_pdc_q + $signed({48'b0, {16{e2_pdc_q[63]}}});
    pmaj_a = e5_pmaj_q + $signed({50'b0, {16{e5_pmaj_q[65]}}});
    pmnr_a = e5_pmnr_q + $signed({50'b0, {16{e5_pmnr_q[65]}}});
    vmaj   = 50'(pmaj_a >>> 16);
    vmnr   = 50'(pmnr_a >>> 16);
    if (vmaj > SAT_HI)      smaj = 32'(SAT_HI);
    else if (vmaj < SAT_LO) smaj = 32'(SAT_LO);
    else                    smaj = 32'(vmaj);
    if (vmnr > SAT_HI)      smnr = 32'(SAT_HI);
    else if (vmnr < SAT_LO) smnr = 32'(SAT_LO);
    else                    smnr = 32'(vmnr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q  <= 1'b0;
      e2_valid_q  <= 1'b0;
      e3_valid_q  <= 1'b0;
      e4_valid_q  <= 1'b0;
      e5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      e1_valid_q  <= dv_valid;
      e2_valid_q  <= e1_valid_q;
      e3_valid_q  <= e2_valid_q;
      e4_valid_q  <= e3_valid_q;
      e5_valid_q  <= e4_valid_q;
      out_valid_q <= e5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_cmd_q    <= t_cmd;
      e1_inside_q <= t_inside;
      e1_env_q    <= env_d;
      e1_dq_q     <= dq_d;
      e1_sn_q     <= rom[t_addr];
      e1_cs_q     <= rom[t_addr + QTR];

      e2_cmd_q    <= e1_cmd_q;
      e2_inside_q <= e1_inside_q;
      e2_pes_q    <= $signed({1'b0, e1_env_q}) * e1_sn_q;
      e2_pec_q    <= $signed({1'b0, e1_env_q}) * e1_cs_q;
      e2_pds_q    <= e1_dq_q * e1_sn_q;
      e2_pdc_q    <= e1_dq_q * e1_cs_q;

      e3_cmd_q    <= e2_cmd_q;
      e3_inside_q <= e2_inside_q;
      e3_es_q     <= 34'(pes_a >>> tpfg_pkg::ENV_FRAC);
      e3_ec_q     <= 34'(pec_a >>> tpfg_pkg::ENV_FRAC);
      e3_ds_q     <= 48'(pds_a >>> 16);
      e3_dc_q     <= 48'(pdc_a >>> 16);

      e4_inside_q <= e3_inside_q;
      if (e3_cmd_q) begin
        e4_maj_q <= 49'(e3_ec_q) + 49'(e3_ds_q);
        e4_mnr_q <= 49'(e3_es_q) - 49'(e3_dc_q);
      end else begin
        e4_maj_q <= -49'(e3_es_q);
        e4_mnr_q <= 49'(e3_ec_q);
      end

      e5_inside_q <= e4_inside_q;
      e5_pmaj_q   <= e4_maj_q * $signed({1'b0, regs_i.major_amp});
      e5_pmnr_q   <= e4_mnr_q * $signed({1'b0, regs_i.minor_amp});

      out_inside_q <= e5_inside_q;
      out_maj_q    <= smaj;
      out_mnr_q    <= smnr;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign major_component_o = out_maj_q;
  assign minor_component_o = out_mnr_q;
  assign in_pulse_o        = out_inside_q;

endmodule
`default_nettype wire

@@ sv/trapezoidal_pulse_field_generator_top.sv @@
// Path: front stages, FIFO, entry stage, envelope divider, E1 to E5, output register.
// Throughput: one word per cycle while not held off as below; the whole back pipeline
// holds while a result is stalled. Reset: registers clear to 0, ramp slopes to full scale;
// no words in flight. After any configuration write, inputs and further writes are held
// off while the serial multiply/divide recomputes both ramp slopes.
`default_nettype none
module trapezoidal_pulse_field_generator_top #(
  parameter int unsigned TIME_WIDTH     = tpfg_pkg::TIME_WIDTH_DEF,
  parameter int unsigned SINE_ADDR_BITS = tpfg_pkg::SINE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_WIDTH   = tpfg_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic [31:0]        time_tick_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      major_component_o,
  output logic signed [31:0]      minor_component_o,
  output logic                    in_pulse_o
);

  localparam int unsigned QW = 1 + 2 + 1 + TIME_WIDTH + 32;

  tpfg_pkg::cfg_regs_t   regs;
  logic [TIME_WIDTH+1:0] t2, t3;
  logic                  busy;

  logic                  push, push_ok, pop, nonempty;
  logic                  f_cmd, f_inside;
  tpfg_pkg::seg_e        f_seg;
  logic [TIME_WIDTH-1:0] f_num;
  logic [31:0]           f_phase;
  logic [QW-1:0]         q_out;

  logic                  b_cmd, b_inside;
  tpfg_pkg::seg_e        b_seg;
  logic [TIME_WIDTH-1:0] b_num;
  logic [31:0]           b_phase;

  tpfg_cfg #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .regs_o      (regs),
    .t2_o        (t2),
    .t3_o        (t3),
    .busy_o      (busy)
  );

  tpfg_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .time_tick_i (time_tick_i),
    .regs_i      (regs),
    .t2_i        (t2),
    .t3_i        (t3),
    .busy_i      (busy),
    .push_ok_i   (push_ok),
    .push_o      (push),
    .cmd_o       (f_cmd),
    .seg_o       (f_seg),
    .inside_o    (f_inside),
    .num_o       (f_num),
    .phase_o     (f_phase)
  );

  tpfg_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     ({f_cmd, f_seg, f_inside, f_num, f_phase}),
    .push_ok_o  (push_ok),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .data_o     (q_out)
  );

  assign {b_cmd, b_seg, b_inside, b_num, b_phase} = q_out;

  tpfg_back #(
    .TIME_WIDTH     (TIME_WIDTH),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .regs_i            (regs),
    .nonempty_i        (nonempty),
    .pop_o             (pop),
    .cmd_i             (b_cmd),
    .seg_i             (b_seg),
    .inside_i          (b_inside),
    .num_i             (b_num),
    .phase_i           (b_phase),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .major_component_o (major_component_o),
    .minor_component_o (minor_component_o),
    .in_pulse_o        (in_pulse_o)
  );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic        cmd;
    logic [31:0] tick;
  } sample_t;

  typedef struct {
    logic signed [31:0] major;
    logic signed [31:0] minor;
    logic               pulse_on;
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic command = 1'b0;
  logic [31:0] time_tick = '0;
  logic out_stall = 1'b0;
  wire cfg_ready, in_stall, out_valid, in_pulse;
  wire signed [31:0] major_c, minor_c;

  trapezoidal_pulse_field_generator_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .time_tick_i(time_tick),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .major_component_o(major_c), .minor_component_o(minor_c),
    .in_pulse_o(in_pulse)
  );

  always #5 clk_i = ~clk_i;

  // register shadow
  logic [15:0] amp_major = '0, amp_minor = '0;
  logic [31:0] carrier_step = '0, carrier_offset = '0, delay_ticks = '0;
  logic [31:0] rise_len = '0, flat_len = '0, fall_len = '0;

  sample_t pending_samples[$];
  field_t  expected_fields[$];
  int errors = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint signed quarter_wave(longint unsigned k);
    longint unsigned x, x2, r;
    x  = (k * 64'd1686629713) >> (tpfg_pkg::SINE_ADDR_BITS_DEF - 2);
    x2 = (x * x) >> 30;
    r  = 64'd1 << 30;
    for (int j = 8; j >= 1; j--)
      r = (64'd1 << 30) - ((x2 * r) >> 30) / longint'((2 * j) * (2 * j + 1));
    return longint'((x * r) >> 30);
  endfunction

  function automatic longint signed carrier_sine(longint unsigned addr);
    longint unsigned n, a, q, k;
    longint signed v;
    n = 64'd1 << (tpfg_pkg::SINE_ADDR_BITS_DEF - 2);
    a = addr & ((64'd1 << tpfg_pkg::SINE_ADDR_BITS_DEF) - 1);
    q = a >> (tpfg_pkg::SINE_ADDR_BITS_DEF - 2);
    k = a & (n - 1);
    v = q[0] ? quarter_wave(n - k) : quarter_wave(k);
    return q[1] ? -v : v;
  endfunction

  function automatic longint signed slope_over_omega(longint unsigned len);
    longint unsigned den, q;
    den = longint'(carrier_step) * len;
    if (den == 0) return 64'd2147483647;
    q = 64'd44798133900175 / den;
    return (q > 64'd2147483647) ? 64'd2147483647 : q;
  endfunction

  function automatic longint signed clip32(longint signed v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic field_t pulse_field(sample_t s);
    field_t f;
    longint unsigned t, tt, t1, t2, t3, env, addr;
    longint signed dq, sn, cs, es, ec, maj, mnr;
    logic [31:0] phase;
    f.major = '0; f.minor = '0; f.pulse_on = 1'b0;
    t = s.tick;
    if (t < delay_ticks) return f;
    tt = t - delay_ticks;
    t1 = rise_len;
    t2 = t1 + flat_len;
    t3 = t2 + fall_len;
    f.pulse_on = (tt > 0 && tt < t3);
    env = 0; dq = 0;
    if (tt == 0) env = 0;
    else if (tt <= t1) begin
      env = (tt << 30) / t1;
      dq = slope_over_omega(t1);
    end else if (tt <= t2) env = 64'd1 << 30;
    else if (tt <= t3) begin
      env = ((t3 - tt) << 30) / longint'(fall_len);
      dq = -slope_over_omega(fall_len);
    end
    phase = carrier_step * tt[31:0] + carrier_offset;
    addr = phase >> (32 - tpfg_pkg::SINE_ADDR_BITS_DEF);
    sn = carrier_sine(addr);
    cs = carrier_sine(addr + (64'd1 << (tpfg_pkg::SINE_ADDR_BITS_DEF - 2)));
    es = (longint'(env) * sn) / 64'sd1073741824;
    ec = (longint'(env) * cs) / 64'sd1073741824;
    if (s.cmd == 1'b0) begin
      maj = -es;
      mnr = ec;
    end else begin
      maj = ec + (dq * sn) / 64'sd65536;
      mnr = es - (dq * cs) / 64'sd65536;
    end
    f.major = clip32((maj * longint'(amp_major)) / 64'sd65536);
    f.minor = clip32((mnr * longint'(amp_minor)) / 64'sd65536);
    return f;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_fields.push_back(pulse_field(pending_samples.pop_front()));
        if ($urandom_range(0, 40) == 0) burst = ~burst;
        send_gap = burst ? 0 : $urandom_range(0, 13);
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          command <= pending_samples[0].cmd;
          time_tick <= pending_samples[0].tick;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          command <= pending_samples[0].cmd;
          time_tick <= pending_samples[0].tick;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_fields.size() == 0) begin
          report("unexpected word", major_c, 0);
        end else begin
          field_t e;
          e = expected_fields.pop_front();
          if (major_c !== e.major) report("major", major_c, e.major);
          if (minor_c !== e.minor) report("minor", minor_c, e.minor);
          if (in_pulse !== e.pulse_on) report("in_pulse", in_pulse, e.pulse_on);
        end
        recv_gap = burst ? 0 : $urandom_range(0, 13);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(tpfg_pkg::cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tpfg_pkg::CFG_MAJOR_AMP:     amp_major = data[15:0];
      tpfg_pkg::CFG_MINOR_AMP:     amp_minor = data[15:0];
      tpfg_pkg::CFG_PHASE_STEP:    carrier_step = data;
      tpfg_pkg::CFG_PHASE_OFFSET:  carrier_offset = data;
      tpfg_pkg::CFG_START_DELAY:   delay_ticks = data;
      tpfg_pkg::CFG_RAMP_UP_LEN:   rise_len = data;
      tpfg_pkg::CFG_PLATEAU_LEN:   flat_len = data;
      default:                     fall_len = data;
    endcase
  endtask

  task automatic setup(logic [15:0] amj, logic [15:0] amn, logic [31:0] stp,
                       logic [31:0] ofs, logic [31:0] dly, logic [31:0] up,
                       logic [31:0] flat, logic [31:0] dn);
    write_reg(tpfg_pkg::CFG_MAJOR_AMP, {$urandom} & 32'hffff_0000 | amj);
    write_reg(tpfg_pkg::CFG_MINOR_AMP, amn);
    write_reg(tpfg_pkg::CFG_PHASE_STEP, stp);
    write_reg(tpfg_pkg::CFG_PHASE_OFFSET, ofs);
    write_reg(tpfg_pkg::CFG_START_DELAY, dly);
    write_reg(tpfg_pkg::CFG_RAMP_UP_LEN, up);
    write_reg(tpfg_pkg::CFG_PLATEAU_LEN, flat);
    write_reg(tpfg_pkg::CFG_RAMP_DOWN_LEN, dn);
  endtask

  task automatic push(logic cmd, logic [31:0] tick);
    sample_t s;
    s.cmd = cmd;
    s.tick = tick;
    pending_samples.push_back(s);
  endtask

  task automatic drain;
    while (pending_samples.size() > 0 || expected_fields.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic push_random(int n);
    longint unsigned span;
    logic [31:0] tk;
    span = longint'(rise_len) + flat_len + fall_len + 4;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) tk = $urandom;
      else if (span > 64'hffff_ffff || $urandom_range(0, 9) == 0)
        tk = delay_ticks + $urandom;
      else tk = delay_ticks + 32'(($urandom % (span + 2)) - 2);
      push($urandom_range(0, 1), tk);
    end
  endtask

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return $urandom;
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic logic [15:0] rand_amp();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // directed: edges of the trapezoid, both commands
    setup(16'hffff, 16'hffff, 32'h0123_4567, 32'h4000_0000, 100, 50, 30, 40);
    push(0, 0); push(1, 99); push(0, 100); push(1, 100); push(0, 101); push(1, 125);
    push(0, 150); push(1, 150); push(1, 151); push(0, 180); push(1, 180);
    push(1, 181); push(0, 219); push(1, 220); push(0, 221); push(1, 32'hffff_ffff);
    drain();
    // zero carrier step and very steep slopes
    setup(16'hffff, 16'h8000, 0, 32'hffff_ffff, 0, 1, 0, 1);
    push(1, 1); push(1, 2); push(0, 1); push(1, 0);
    drain();
    write_reg(tpfg_pkg::CFG_PHASE_STEP, 1);
    push(1, 1); push(1, 2);
    drain();
    // register extremes
    setup(16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push(1, 32'hffff_ffff); push(0, 32'hfffffffe);
    drain();
    setup(0, 0, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push(1, 32'h8000_0000); push(0, 32'hffff_ffff);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      setup(rand_amp(), rand_amp(),
            ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom >> $urandom_range(0, 24),
            $urandom, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 500),
            rand_len(), rand_len(), rand_len());
      push_random(40);
      drain();
      push_random(40);
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
